[design/mcp_pkg.sv]
// shared types and constants of the motor command parser
package mcp_pkg;

  // command length limit and field widths
  localparam int MAX_COMMAND_CHARS = 16;
  localparam int POS_W = $clog2(MAX_COMMAND_CHARS + 1);
  localparam int LEN_W = 5;
  localparam int ACC_W = 50;
  localparam int SCALE_W = 4;
  localparam int MANT_W = ACC_W + 1;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] ACC_SAT_LIMIT = (ACC_MAX - ACC_W'(9)) / ACC_W'(10);
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

  // characters of interest
  localparam logic [7:0] CH_R_UP = 8'h52;
  localparam logic [7:0] CH_R_LO = 8'h72;
  localparam logic [7:0] CH_V_UP = 8'h56;
  localparam logic [7:0] CH_V_LO = 8'h76;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // scan phase codes
  localparam logic [1:0] PH_SCAN = 2'd0;
  localparam logic [1:0] PH_ROT_DONE = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // number mode codes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ROT = 2'd1;
  localparam logic [1:0] MODE_VEL = 2'd2;

  // one accepted input word
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } cmd_word_t;

  // parsed result, magnitude and sign kept apart
  typedef struct packed {
    logic               rot_given;
    logic               rot_neg;
    logic [ACC_W-1:0]   rot_mag;
    logic [SCALE_W-1:0] rot_scale;
    logic               vel_given;
    logic               vel_neg;
    logic [ACC_W-1:0]   vel_mag;
    logic [SCALE_W-1:0] vel_scale;
  } result_t;

endpackage

[design/mcp_in_if.sv]
// command character channel of the motor command parser
interface mcp_in_if;
  import mcp_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source(output valid, character, last, input ready);
  modport sink(input valid, character, last, output ready);
endinterface

[design/mcp_out_if.sv]
// result channel of the motor command parser
interface mcp_out_if;
  import mcp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      rotation_given;
  logic signed [MANT_W-1:0]  rotation_mantissa;
  logic [SCALE_W-1:0]        rotation_fraction_digits;
  logic                      velocity_given;
  logic signed [MANT_W-1:0]  velocity_mantissa;
  logic [SCALE_W-1:0]        velocity_fraction_digits;

  modport source(output valid, rotation_given, rotation_mantissa, rotation_fraction_digits,
                 velocity_given, velocity_mantissa, velocity_fraction_digits, input ready);
  modport sink(input valid, rotation_given, rotation_mantissa, rotation_fraction_digits,
               velocity_given, velocity_mantissa, velocity_fraction_digits, output ready);
endinterface

[design/mcp_core.sv]
// parser state and per-character update of the motor command parser
module mcp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mcp_pkg::cmd_word_t word,
  output logic               result_valid,
  output mcp_pkg::result_t   result
);
  import mcp_pkg::*;

  typedef struct packed {
    logic [1:0]         phase;
    logic [1:0]         mode;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   len;
    logic [ACC_W-1:0]   acc;
    logic               neg;
    logic               point;
    logic [SCALE_W-1:0] frac;
    logic               rot_found;
    logic [ACC_W-1:0]   rot_mag;
    logic               rot_neg;
    logic [SCALE_W-1:0] rot_scale;
    logic               vel_found;
    logic [ACC_W-1:0]   vel_mag;
    logic               vel_neg;
    logic [SCALE_W-1:0] vel_scale;
  } parse_state_t;

  parse_state_t st;
  parse_state_t st_next;
  parse_state_t fin;

  // drop the number being read
  function automatic parse_state_t clear_number(parse_state_t s);
    parse_state_t t;
    t = s;
    t.len = '0;
    t.acc = '0;
    t.neg = 1'b0;
    t.point = 1'b0;
    t.frac = '0;
    return t;
  endfunction

  // close the number, keep it if it held any character
  function automatic parse_state_t end_number(parse_state_t s);
    parse_state_t t;
    t = s;
    if (t.mode != MODE_NONE && t.len != '0) begin
      if (t.mode == MODE_ROT) begin
        t.rot_found = 1'b1;
        t.rot_mag = t.acc;
        t.rot_neg = t.neg;
        t.rot_scale = t.frac;
        t.phase = PH_ROT_DONE;
      end else begin
        t.vel_found = 1'b1;
        t.vel_mag = t.acc;
        t.vel_neg = t.neg;
        t.vel_scale = t.frac;
        t.phase = PH_DONE;
      end
    end
    t.mode = MODE_NONE;
    return clear_number(t);
  endfunction

  // look for a letter that opens a number
  function automatic parse_state_t scan_char(parse_state_t s, logic [7:0] c);
    parse_state_t t;
    t = s;
    if (t.phase == PH_SCAN && (c == CH_R_UP || c == CH_R_LO)) begin
      t.mode = MODE_ROT;
      t = clear_number(t);
    end else if (t.phase < PH_DONE && (c == CH_V_UP || c == CH_V_LO)) begin
      t.mode = MODE_VEL;
      t = clear_number(t);
    end
    return t;
  endfunction

  // one character inside a number
  function automatic parse_state_t number_char(parse_state_t s, logic [7:0] c);
    parse_state_t     t;
    logic [7:0]       dsub;
    logic [ACC_W-1:0] times_ten;
    t = s;
    dsub = c - CH_ZERO;
    times_ten = (t.acc << 3) + (t.acc << 1) + ACC_W'(dsub[3:0]);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t.acc = (t.acc > ACC_SAT_LIMIT) ? ACC_MAX : times_ten;
      if (t.point && t.frac != SCALE_MAX) begin
        t.frac = t.frac + SCALE_W'(1);
      end
      if (t.len != LEN_MAX) begin
        t.len = t.len + LEN_W'(1);
      end
    end else if (c == CH_POINT) begin
      if (t.len == '0 || t.point) begin
        t.mode = MODE_NONE;
        t = clear_number(t);
      end else begin
        t.point = 1'b1;
        if (t.len != LEN_MAX) begin
          t.len = t.len + LEN_W'(1);
        end
      end
    end else if (c == CH_MINUS) begin
      if (t.len != '0) begin
        t.mode = MODE_NONE;
        t = clear_number(t);
      end else begin
        t.neg = 1'b1;
        t.len = t.len + LEN_W'(1);
      end
    end else begin
      t = end_number(t);
      t = scan_char(t, c);
    end
    return t;
  endfunction

  // per-character update and end of string
  always_comb begin
    parse_state_t s;
    s = st;
    if (s.pos >= POS_W'(MAX_COMMAND_CHARS)) begin
      if (s.mode != MODE_NONE) begin
        s = end_number(s);
      end
    end else begin
      s.pos = s.pos + POS_W'(1);
      if (s.phase < PH_DONE) begin
        if (s.mode != MODE_NONE) begin
          s = number_char(s, word.character);
        end else begin
          s = scan_char(s, word.character);
        end
      end
    end
    fin = (s.mode != MODE_NONE) ? end_number(s) : s;
    st_next = word.last ? '0 : s;
  end

  // result word from the closed state
  always_comb begin
    result.rot_given = fin.rot_found;
    result.rot_neg = fin.rot_found & fin.rot_neg;
    result.rot_mag = fin.rot_found ? fin.rot_mag : '0;
    result.rot_scale = fin.rot_found ? fin.rot_scale : '0;
    result.vel_given = fin.vel_found;
    result.vel_neg = fin.vel_found & fin.vel_neg;
    result.vel_mag = fin.vel_found ? fin.vel_mag : '0;
    result.vel_scale = fin.vel_found ? fin.vel_scale : '0;
  end

  assign result_valid = step & word.last;

  // parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

[design/motor_command_parser.sv]
// motor command parser: characters in, rotation and velocity numbers out
// throughput: one character word per cycle while not stalled, no gaps between strings
// result path: input register, then combinational core, then result register
// the only stall is a last character waiting while the result register is still full
// reset (synchronous, active high) empties both registers and returns the parser to
// the start of a string
module motor_command_parser (
  input logic      clk,
  input logic      rst,
  mcp_in_if.sink   cmd,
  mcp_out_if.source result
);
  import mcp_pkg::*;

  logic      s1_valid;
  cmd_word_t s1_word;
  logic      advance;
  logic      res_valid;
  result_t   res_data;
  logic      out_valid;
  result_t   out_data;

  // input stage moves on unless a last word finds the result register full and not ready
  assign advance = s1_valid && (!s1_word.last || !out_valid || result.ready);
  assign cmd.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_word.character <= cmd.character;
      s1_word.last <= cmd.last;
    end
  end

  mcp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .word         (s1_word),
    .result_valid (res_valid),
    .result       (res_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res_data;
    end
  end

  // sign applied on the way out
  assign result.valid = out_valid;
  assign result.rotation_given = out_data.rot_given;
  assign result.rotation_mantissa = out_data.rot_neg ? -$signed({1'b0, out_data.rot_mag})
                                                     : $signed({1'b0, out_data.rot_mag});
  assign result.rotation_fraction_digits = out_data.rot_scale;
  assign result.velocity_given = out_data.vel_given;
  assign result.velocity_mantissa = out_data.vel_neg ? -$signed({1'b0, out_data.vel_mag})
                                                     : $signed({1'b0, out_data.vel_mag});
  assign result.velocity_fraction_digits = out_data.vel_scale;

`ifndef SYNTH
  // a new result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || result.ready))
    else $error("result register overwritten");

  // a held input word keeps its contents
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_word)))
    else $error("input stage lost a word");

  // a rotation not given reads as zero
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.rot_given) |->
      (out_data.rot_mag == '0 && out_data.rot_scale == '0 && !out_data.rot_neg))
    else $error("absent rotation not zero");
`endif

endmodule

[tb/tb_top.sv]
// self-checking testbench of the motor command parser with its own parse predictor
module tb_top;
  import mcp_pkg::*;

  localparam int RANDOM_WORDS = 900;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [7:0] CH_SEPARATOR = 8'h2c;

  typedef logic [7:0] char_q_t[$];

  // one parsed command as the block should report it
  typedef struct packed {
    logic               rot_given;
    logic [MANT_W-1:0]  rot_mant;
    logic [SCALE_W-1:0] rot_frac;
    logic               vel_given;
    logic [MANT_W-1:0]  vel_mant;
    logic [SCALE_W-1:0] vel_frac;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst;

  mcp_in_if  cmd_if();
  mcp_out_if res_if();

  motor_command_parser dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .result(res_if)
  );

  always #5 clk = ~clk;

  parse_result_t expected_parses[$];
  char_q_t       cmd_buf;
  int            mismatch_count = 0;
  int            sent_words = 0;
  logic          sender_quiet = 1'b0;
  logic          receiver_quiet = 1'b0;
  logic          hold_request = 1'b0;

  // parser state mirrored by the predictor
  logic [1:0]         pr_phase;
  logic [1:0]         pr_mode;
  int                 pr_pos;
  logic [LEN_W-1:0]   pr_len;
  logic [ACC_W-1:0]   pr_acc;
  logic               pr_neg;
  logic               pr_point;
  logic [SCALE_W-1:0] pr_frac;
  logic               rot_found;
  logic [MANT_W-1:0]  rot_value;
  logic [SCALE_W-1:0] rot_scale;
  logic               vel_found;
  logic [MANT_W-1:0]  vel_value;
  logic [SCALE_W-1:0] vel_scale;

  function automatic void clear_number();
    pr_len = '0;
    pr_acc = '0;
    pr_neg = 1'b0;
    pr_point = 1'b0;
    pr_frac = '0;
  endfunction

  function automatic void restart_parse();
    pr_phase = PH_SCAN;
    pr_mode = MODE_NONE;
    pr_pos = 0;
    clear_number();
    rot_found = 1'b0;
    rot_value = '0;
    rot_scale = '0;
    vel_found = 1'b0;
    vel_value = '0;
    vel_scale = '0;
  endfunction

  // a finished number with at least one character is stored
  function automatic void close_number();
    logic [MANT_W-1:0] value;
    value = pr_neg ? (MANT_W'(0) - {1'b0, pr_acc}) : {1'b0, pr_acc};
    if (pr_mode != MODE_NONE && pr_len != 0) begin
      if (pr_mode == MODE_ROT) begin
        rot_found = 1'b1;
        rot_value = value;
        rot_scale = pr_frac;
        pr_phase = PH_ROT_DONE;
      end else begin
        vel_found = 1'b1;
        vel_value = value;
        vel_scale = pr_frac;
        pr_phase = PH_DONE;
      end
    end
    pr_mode = MODE_NONE;
    clear_number();
  endfunction

  function automatic void scan_letter(input logic [7:0] c);
    if (pr_phase == PH_SCAN && (c == CH_R_UP || c == CH_R_LO)) begin
      pr_mode = MODE_ROT;
      clear_number();
    end else if (pr_phase < PH_DONE && (c == CH_V_UP || c == CH_V_LO)) begin
      pr_mode = MODE_VEL;
      clear_number();
    end
  endfunction

  function automatic void number_char(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (pr_acc > ACC_SAT_LIMIT) begin
        pr_acc = ACC_MAX;
      end else begin
        pr_acc = pr_acc * ACC_W'(10) + ACC_W'(c - CH_ZERO);
      end
      if (pr_point && pr_frac != SCALE_MAX) pr_frac = pr_frac + 1'b1;
      if (pr_len != LEN_MAX) pr_len = pr_len + 1'b1;
    end else if (c == CH_POINT) begin
      // point first or a second point throws the number away
      if (pr_len == 0 || pr_point) begin
        pr_mode = MODE_NONE;
        clear_number();
      end else begin
        pr_point = 1'b1;
        if (pr_len != LEN_MAX) pr_len = pr_len + 1'b1;
      end
    end else if (c == CH_MINUS) begin
      // sign only allowed as first character
      if (pr_len != 0) begin
        pr_mode = MODE_NONE;
        clear_number();
      end else begin
        pr_neg = 1'b1;
        pr_len = pr_len + 1'b1;
      end
    end else begin
      close_number();
      scan_letter(c);
    end
  endfunction

  // advance the predictor by one accepted word, queue the result on last
  function automatic void parse_char(input logic [7:0] c, input logic is_last);
    parse_result_t want;
    if (pr_pos >= MAX_COMMAND_CHARS) begin
      if (pr_mode != MODE_NONE) close_number();
    end else begin
      pr_pos++;
      if (pr_phase < PH_DONE) begin
        if (pr_mode != MODE_NONE) number_char(c);
        else scan_letter(c);
      end
    end
    if (is_last) begin
      if (pr_mode != MODE_NONE) close_number();
      want.rot_given = rot_found;
      want.rot_mant = rot_found ? rot_value : '0;
      want.rot_frac = rot_found ? rot_scale : '0;
      want.vel_given = vel_found;
      want.vel_mant = vel_found ? vel_value : '0;
      want.vel_frac = vel_found ? vel_scale : '0;
      expected_parses.push_back(want);
      restart_parse();
    end
  endfunction

  // gap lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one word and wait for the handshake
  task automatic send_word(input logic [7:0] c, input logic is_last);
    int gap;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.character <= c;
    cmd_if.last <= is_last;
    do @(posedge clk); while (!cmd_if.ready);
    parse_char(c, is_last);
    sent_words++;
  endtask

  task automatic send_command();
    for (int i = 0; i < cmd_buf.size(); i++) begin
      send_word(cmd_buf[i], i == cmd_buf.size() - 1);
    end
  endtask

  task automatic send_text(input string t);
    cmd_buf.delete();
    for (int i = 0; i < t.len(); i++) cmd_buf.push_back(t[i]);
    send_command();
  endtask

  // character generators
  function automatic logic [7:0] digit_char();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rot_letter();
    return $urandom_range(0, 1) ? CH_R_UP : CH_R_LO;
  endfunction

  function automatic logic [7:0] vel_letter();
    return $urandom_range(0, 1) ? CH_V_UP : CH_V_LO;
  endfunction

  // biased toward characters the parser reacts to
  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 7))
      0: return digit_char();
      1: return CH_MINUS;
      2: return CH_POINT;
      3: return rot_letter();
      4: return vel_letter();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // well formed number: optional sign, digits, optional point
  function automatic void append_number();
    int n;
    int dot_at;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 6);
    dot_at = $urandom_range(0, 1) ? $urandom_range(1, n) : 0;
    if ($urandom_range(0, 2) == 0) cmd_buf.push_back(CH_MINUS);
    for (int i = 0; i < n; i++) begin
      cmd_buf.push_back(digit_char());
      if (i + 1 == dot_at) cmd_buf.push_back(CH_POINT);
    end
  endfunction

  function automatic void build_random_command();
    cmd_buf.delete();
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) cmd_buf.push_back(junk_char());
      if ($urandom_range(0, 4) != 0) begin
        cmd_buf.push_back(rot_letter());
        append_number();
      end
      if ($urandom_range(0, 3) == 0) cmd_buf.push_back(CH_SEPARATOR);
      if ($urandom_range(0, 4) != 0) begin
        cmd_buf.push_back(vel_letter());
        append_number();
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) cmd_buf.push_back(junk_char());
      if (cmd_buf.size() == 0) cmd_buf.push_back(junk_char());
    end else begin
      repeat ($urandom_range(1, 20)) cmd_buf.push_back(junk_char());
    end
  endfunction

  // signs, fractions, lower case letters, lone sign, trailing point
  task automatic test_number_forms();
    send_text("R-1.5V-.5");
    send_text("r-");
    send_text("v3.");
    send_text("R42,V7");
  endtask

  // misplaced sign or point, empty numbers, letters out of phase
  task automatic test_malformed_numbers();
    send_text("R.5V1");
    send_text("R1-2V3");
    send_text("R1.2.3");
    send_text("RV");
    send_text("V1R2");
  endtask

  // nul and top code as plain characters
  task automatic test_odd_characters();
    send_word(CH_R_UP, 1'b0);
    send_word(CH_NINE, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(8'h00, 1'b1);
  endtask

  // strings past the length limit, largest magnitudes
  task automatic test_long_strings();
    send_text("R999999999999999V9");
    send_text("V-99999999.999999");
  endtask

  // receiver holds off while commands keep coming
  task automatic test_back_pressure();
    sender_quiet = 1'b1;
    hold_request = 1'b1;
    repeat (10) begin
      build_random_command();
      send_command();
    end
    sender_quiet = 1'b0;
  endtask

  task automatic test_random_commands();
    int target;
    target = sent_words + RANDOM_WORDS;
    while (sent_words < target) begin
      if ($urandom_range(0, 19) == 0) sender_quiet = ~sender_quiet;
      if ($urandom_range(0, 19) == 0) receiver_quiet = ~receiver_quiet;
      build_random_command();
      send_command();
    end
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // result side ready, random stalls and one long hold on request
  initial begin : result_sink
    int stall_left;
    res_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (!receiver_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result word with the oldest expected parse
  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_parses.size() == 0) begin
        $display("%0t: unexpected result word, rotation %0d velocity %0d", $time,
                 res_if.rotation_mantissa, res_if.velocity_mantissa);
        mismatch_count++;
      end else begin
        want = expected_parses.pop_front();
        check_field("rotation_given", want.rot_given, res_if.rotation_given);
        check_field("rotation_mantissa", $signed(want.rot_mant), res_if.rotation_mantissa);
        check_field("rotation_fraction_digits", want.rot_frac, res_if.rotation_fraction_digits);
        check_field("velocity_given", want.vel_given, res_if.velocity_given);
        check_field("velocity_mantissa", $signed(want.vel_mant), res_if.velocity_mantissa);
        check_field("velocity_fraction_digits", want.vel_frac, res_if.velocity_fraction_digits);
      end
    end
  end

  // watchdog
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.character = '0;
    cmd_if.last = 1'b0;
    restart_parse();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_number_forms();
    test_malformed_numbers();
    test_odd_characters();
    test_long_strings();
    test_back_pressure();
    test_random_commands();

    // drain outstanding results
    cmd_if.valid <= 1'b0;
    while (expected_parses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
